// ===== rtl/whirl_source_coordinate_macros.svh =====
// Assertion macros for the whirl source coordinate block.
// Used by whirl_source_coordinate.sv; expects clk and arst_n in scope.
`ifndef WHIRL_SOURCE_COORDINATE_MACROS_SVH
`define WHIRL_SOURCE_COORDINATE_MACROS_SVH
`ifndef SYNTHESIS
// checked only out of reset
`define WSC_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("whirl source coordinate check failed");
// checked on every edge, reset included
`define WSC_ASSERT_ALWAYS(label, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("whirl source coordinate check failed");
`else
`define WSC_ASSERT(label, prop)
`define WSC_ASSERT_ALWAYS(label, prop)
`endif
`endif

// ===== rtl/wsc_pkg.sv =====
// Shared types, constants and Q14 sine/cosine tables for the whirl source coordinate block.
// No dependencies.
package wsc_pkg;
	localparam int MaxDim   = 2048;
	localparam int Q14One   = 16384;
	localparam int CfgRegs  = 5;

	localparam logic [2:0] REG_FRAME_STEP    = 3'd0;
	localparam logic [2:0] REG_EFFECT_LENGTH = 3'd1;
	localparam logic [2:0] REG_TURN_REVERSE  = 3'd2;
	localparam logic [2:0] REG_FRAME_WIDTH   = 3'd3;
	localparam logic [2:0] REG_FRAME_HEIGHT  = 3'd4;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LOAD = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_LUT  = 2'd3;

	// one digit of the square root: value left to consume, remainder, root so far
	typedef struct packed {
		logic [27:0] val;
		logic [16:0] rem;
		logic [13:0] root;
	} sqs_t;

	function automatic logic [14:0] qsin(input logic [6:0] k);
		logic [14:0] v;
		case (k)
			7'd0:  v = 15'd0;     7'd1:  v = 15'd402;   7'd2:  v = 15'd803;
			7'd3:  v = 15'd1205;  7'd4:  v = 15'd1605;  7'd5:  v = 15'd2005;
			7'd6:  v = 15'd2404;  7'd7:  v = 15'd2801;  7'd8:  v = 15'd3196;
			7'd9:  v = 15'd3589;  7'd10: v = 15'd3980;  7'd11: v = 15'd4369;
			7'd12: v = 15'd4756;  7'd13: v = 15'd5139;  7'd14: v = 15'd5519;
			7'd15: v = 15'd5896;  7'd16: v = 15'd6269;  7'd17: v = 15'd6639;
			7'd18: v = 15'd7005;  7'd19: v = 15'd7366;  7'd20: v = 15'd7723;
			7'd21: v = 15'd8075;  7'd22: v = 15'd8423;  7'd23: v = 15'd8765;
			7'd24: v = 15'd9102;  7'd25: v = 15'd9434;  7'd26: v = 15'd9759;
			7'd27: v = 15'd10079; 7'd28: v = 15'd10393; 7'd29: v = 15'd10701;
			7'd30: v = 15'd11002; 7'd31: v = 15'd11297; 7'd32: v = 15'd11585;
			7'd33: v = 15'd11866; 7'd34: v = 15'd12139; 7'd35: v = 15'd12406;
			7'd36: v = 15'd12665; 7'd37: v = 15'd12916; 7'd38: v = 15'd13159;
			7'd39: v = 15'd13395; 7'd40: v = 15'd13622; 7'd41: v = 15'd13842;
			7'd42: v = 15'd14053; 7'd43: v = 15'd14255; 7'd44: v = 15'd14449;
			7'd45: v = 15'd14634; 7'd46: v = 15'd14810; 7'd47: v = 15'd14978;
			7'd48: v = 15'd15136; 7'd49: v = 15'd15286; 7'd50: v = 15'd15426;
			7'd51: v = 15'd15557; 7'd52: v = 15'd15678; 7'd53: v = 15'd15790;
			7'd54: v = 15'd15892; 7'd55: v = 15'd15985; 7'd56: v = 15'd16069;
			7'd57: v = 15'd16142; 7'd58: v = 15'd16206; 7'd59: v = 15'd16260;
			7'd60: v = 15'd16305; 7'd61: v = 15'd16339; 7'd62: v = 15'd16364;
			7'd63: v = 15'd16379;
			default: v = 15'd16384;
		endcase
		return v;
	endfunction

	function automatic logic signed [15:0] sin_lut(input logic [7:0] a);
		logic [14:0] m;
		m = a[6] ? qsin(7'd64 - {1'b0, a[5:0]}) : qsin({1'b0, a[5:0]});
		return a[7] ? -$signed({1'b0, m}) : $signed({1'b0, m});
	endfunction

	function automatic logic signed [15:0] cos_lut(input logic [7:0] a);
		return sin_lut(a + 8'd64);
	endfunction

	function automatic sqs_t sqrt_step(input sqs_t st);
		sqs_t        nx;
		logic [16:0] rs;
		logic [16:0] trial;
		rs    = {st.rem[14:0], st.val[27:26]};
		trial = {1'b0, st.root, 2'b01};
		nx.val = {st.val[25:0], 2'b00};
		if (rs >= trial) begin
			nx.rem  = rs - trial;
			nx.root = {st.root[12:0], 1'b1};
		end else begin
			nx.rem  = rs;
			nx.root = {st.root[12:0], 1'b0};
		end
		return nx;
	endfunction
endpackage

// ===== rtl/whirl_source_coordinate.sv =====
// Whirl warp source coordinate generator: top level, full pixel pipeline and frame setup.
// Depends on wsc_pkg and whirl_source_coordinate_macros.svh.
//
// Usage:
//   Input channel in_valid/in_stall carries one destination pixel word (dest_col, dest_row);
//   output channel out_valid/out_stall returns one source pixel word (src_col, src_row).
//   A word moves at a rising edge with valid high and stall low.
//   The configuration port (wr_en, wr_index, wr_data) writes frame_step, effect_length,
//   turn_reverse, frame_width and frame_height at indexes 0 to 4; other indexes are ignored.
//   Throughput is one pixel per clock while in_stall is low. The 15 register stages are:
//   offset, squares, radius sum, four square root stages, wave lookup, wave multiply,
//   angle, sine/cosine lookup, rotation multiply, scaling, recentering and clamp.
//   After reset and after every write to indexes 0 to 4 the frame constants are recomputed
//   by a serial divider (frame_step*64/effect_length, one quotient bit a cycle): in_stall is
//   held high meanwhile. Reset loads 0, 1, 0, 640 and 480 into the registers.
//   When out_stall is high with a word waiting, the whole pipeline holds and in_stall rises;
//   nothing is lost or repeated.
`include "whirl_source_coordinate_macros.svh"
module whirl_source_coordinate (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [10:0] dest_col,
	input  logic [10:0] dest_row,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [10:0] src_col,
	output logic [10:0] src_row,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [15:0] wr_data
);
	import wsc_pkg::*;

	localparam int NStg = 15;

	// configuration
	logic [15:0] step_q, len_q;
	logic        rev_q;
	logic [11:0] width_q, height_q;
	logic [11:0] w_dim, h_dim;
	logic [10:0] cx, cy;
	logic [15:0] len_d;

	// frame setup
	logic [1:0]  st_q;
	logic [4:0]  cnt_q;
	logic [21:0] dq_q;
	logic [15:0] rem_q;
	logic [16:0] div_rs;
	logic        div_ge;
	logic signed [15:0] wa_q, ab_q;
	logic signed [15:0] t_sin, t_cos;
	logic signed [17:0] wsum;
	logic signed [17:0] wa_n;
	logic busy;
	logic adv;

	// pipeline
	logic [NStg:1] vld;
	logic signed [12:0] xp_s [1:11];
	logic signed [12:0] yp_s [1:11];
	logic signed [25:0] xsq, ysq;
	logic [21:0] xx_s2, yy_s2;
	logic signed [24:0] vsum;
	logic [27:0] rad_s3;
	sqs_t sq_s   [0:3];
	sqs_t sq_nx  [0:3];
	sqs_t sq_in  [0:3];
	logic signed [15:0] ws_s8;
	logic signed [31:0] wp_s9;
	logic signed [31:0] th_adj;
	logic signed [17:0] theta;
	logic [7:0]  ang_s10;
	logic signed [15:0] sn_s11, cs_s11;
	logic signed [13:0] x2, y2;
	logic signed [29:0] pc1_s12, ps1_s12, ps2_s12, pc2_s12;
	logic signed [30:0] dj_raw, di_raw;
	logic signed [16:0] dj_s13, di_s13;
	logic signed [17:0] jm1, im1;
	logic signed [17:0] jr_s14, ir_s14;
	logic [10:0] jo_s15, io_s15;

	always_comb begin
		w_dim = (width_q == 12'd0) ? 12'd1 : (width_q > 12'(MaxDim)) ? 12'(MaxDim) : width_q;
		h_dim = (height_q == 12'd0) ? 12'd1
			: (height_q > 12'(MaxDim)) ? 12'(MaxDim) : height_q;
		cx    = w_dim[11:1];
		cy    = h_dim[11:1];
		len_d = (len_q == 16'd0) ? 16'd1 : len_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= '0;
			len_q    <= 16'd1;
			rev_q    <= 1'b0;
			width_q  <= 12'd640;
			height_q <= 12'd480;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_FRAME_STEP:    step_q   <= wr_data;
				REG_EFFECT_LENGTH: len_q    <= wr_data;
				REG_TURN_REVERSE:  rev_q    <= wr_data[0];
				REG_FRAME_WIDTH:   width_q  <= wr_data[11:0];
				REG_FRAME_HEIGHT:  height_q <= wr_data[11:0];
				default: ;
			endcase
		end
	end

	// frame constants: serial divide, then table lookup
	assign div_rs = {rem_q, dq_q[21]};
	assign div_ge = div_rs >= {1'b0, len_d};
	assign t_sin  = sin_lut(dq_q[7:0]);
	assign t_cos  = cos_lut(dq_q[7:0]);
	assign wsum   = 18'(t_sin) + 18'(t_cos) - 18'sd16384;
	// divide by 128, rounding toward zero
	assign wa_n   = (wsum + (wsum[17] ? 18'sd127 : 18'sd0)) >>> 7;
	assign busy   = (st_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_LOAD;
			cnt_q <= '0;
		end else if (wr_en && wr_index < 3'(CfgRegs)) begin
			st_q <= ST_LOAD;
		end else begin
			unique case (st_q)
				ST_LOAD: begin
					st_q  <= ST_DIV;
					cnt_q <= 5'd21;
				end
				ST_DIV: begin
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == 5'd0)
						st_q <= ST_LUT;
				end
				ST_LUT:  st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_LOAD) begin
			dq_q  <= {step_q, 6'b0};
			rem_q <= '0;
		end else if (st_q == ST_DIV) begin
			rem_q <= div_ge ? 16'(div_rs - {1'b0, len_d}) : div_rs[15:0];
			dq_q  <= {dq_q[20:0], div_ge};
		end
		if (st_q == ST_LUT) begin
			wa_q <= wa_n[15:0];
			ab_q <= 16'(18'({2'b0, 16'(17'sd16384 - 17'(t_cos))} >> 6) + wa_n);
		end
	end

	// pipeline control: hold everything while a finished word waits
	assign adv       = !(vld[NStg] && out_stall);
	assign in_stall  = busy || !adv;
	assign out_valid = vld[NStg];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld <= '0;
		else if (adv)
			vld <= {vld[NStg-1:1], in_valid && !in_stall};
	end

	always_comb begin
		xsq  = xp_s[1] * xp_s[1];
		ysq  = yp_s[1] * yp_s[1];
		vsum = $signed({3'b0, xx_s2}) + $signed({3'b0, yy_s2}) + 25'(xp_s[2]) + 25'(yp_s[2]);
		sq_in[0] = '{val: rad_s3, rem: '0, root: '0};
		for (int j = 1; j < 4; j++)
			sq_in[j] = sq_s[j-1];
		for (int j = 0; j < 4; j++) begin
			sq_nx[j] = sq_in[j];
			for (int i = 0; i < 4; i++)
				if (j * 4 + i < 14)
					sq_nx[j] = sqrt_step(sq_nx[j]);
		end
		th_adj = (wp_s9 + (wp_s9[31] ? 32'sd16383 : 32'sd0)) >>> 14;
		theta  = 18'(th_adj) + 18'(ab_q);
		x2     = {xp_s[11], 1'b1};
		y2     = {yp_s[11], 1'b1};
		dj_raw = 31'(pc1_s12) - 31'(ps1_s12);
		di_raw = 31'(ps2_s12) + 31'(pc2_s12);
		jm1    = 18'(dj_s13) - 18'sd1;
		im1    = 18'(di_s13) - 18'sd1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			xp_s[1] <= $signed({2'b0, dest_col}) - $signed({2'b0, cx});
			yp_s[1] <= $signed({2'b0, dest_row}) - $signed({2'b0, cy});
			for (int k = 2; k <= 11; k++) begin
				xp_s[k] <= xp_s[k-1];
				yp_s[k] <= yp_s[k-1];
			end
			xx_s2  <= xsq[21:0];
			yy_s2  <= ysq[21:0];
			rad_s3 <= {vsum[23:0], 4'b1000};
			for (int j = 0; j < 4; j++)
				sq_s[j] <= sq_nx[j];
			ws_s8   <= sin_lut(sq_s[3].root[7:0]);
			wp_s9   <= 32'(wa_q) * 32'(ws_s8);
			ang_s10 <= rev_q ? 8'(-theta) : theta[7:0];
			sn_s11  <= sin_lut(ang_s10);
			cs_s11  <= cos_lut(ang_s10);
			pc1_s12 <= 30'(x2) * 30'(cs_s11);
			ps1_s12 <= 30'(y2) * 30'(sn_s11);
			ps2_s12 <= 30'(x2) * 30'(sn_s11);
			pc2_s12 <= 30'(y2) * 30'(cs_s11);
			// scale back from Q14, rounding toward zero
			dj_s13  <= 17'((dj_raw + (dj_raw[30] ? 31'sd16383 : 31'sd0)) >>> 14);
			di_s13  <= 17'((di_raw + (di_raw[30] ? 31'sd16383 : 31'sd0)) >>> 14);
			jr_s14  <= ((jm1 + (jm1[17] ? 18'sd1 : 18'sd0)) >>> 1) + $signed({7'b0, cx});
			ir_s14  <= ((im1 + (im1[17] ? 18'sd1 : 18'sd0)) >>> 1) + $signed({7'b0, cy});
			// clamp to the screen
			if (jr_s14[17])
				jo_s15 <= '0;
			else if (jr_s14 >= $signed({6'b0, w_dim}))
				jo_s15 <= 11'(w_dim - 12'd1);
			else
				jo_s15 <= jr_s14[10:0];
			if (ir_s14[17])
				io_s15 <= '0;
			else if (ir_s14 >= $signed({6'b0, h_dim}))
				io_s15 <= 11'(h_dim - 12'd1);
			else
				io_s15 <= ir_s14[10:0];
		end
	end

	assign src_col = jo_s15;
	assign src_row = io_s15;

	`WSC_ASSERT_ALWAYS(a_stall_while_setup, busy |-> in_stall)
	`WSC_ASSERT(a_col_on_screen, out_valid |-> ({1'b0, src_col} < w_dim))
	`WSC_ASSERT(a_row_on_screen, out_valid |-> ({1'b0, src_row} < h_dim))
	`WSC_ASSERT(a_write_restarts_setup, (wr_en && wr_index < 3'(CfgRegs)) |=> st_q == ST_LOAD)
endmodule

// ===== dv/tb_whirl_source_coordinate.sv =====
// Self-checking testbench for whirl_source_coordinate: random and directed pixel words,
// register settings and stall patterns, checked against an internal whirl predictor.
// Depends on wsc_pkg and the RTL of whirl_source_coordinate.
module tb_whirl_source_coordinate;
	import wsc_pkg::*;

	localparam logic [2:0] REG_SPARE_LO = 3'd5;
	localparam logic [2:0] REG_SPARE_HI = 3'd7;
	localparam int CycleLimit = 400000;

	typedef struct {
		logic [10:0] col;
		logic [10:0] row;
	} pixel_t;

	class whirl_scoreboard;
		int          sine_q14 [256];
		int          wave_amp;
		int          ang_base;
		logic [15:0] step_reg;
		logic [15:0] length_reg;
		logic        reverse_reg;
		logic [11:0] width_reg;
		logic [11:0] height_reg;
		pixel_t      src_expected [$];
		int          errors;

		function new();
			int k;
			int q;
			for (k = 0; k < 256; k++) begin
				q = k % 64;
				if (k[6]) q = 64 - q;
				sine_q14[k] = (q == 64) ? Q14One :
					int'($floor(16384.0 * $sin(q * 3.14159265358979323846 / 128.0)));
				if (k[7]) sine_q14[k] = -sine_q14[k];
			end
			step_reg = 16'd0;
			length_reg = 16'd1;
			reverse_reg = 1'b0;
			width_reg = 12'd640;
			height_reg = 12'd480;
			errors = 0;
			refresh_frame();
		endfunction

		function int cosine_q14(int a);
			return sine_q14[(a + 64) % 256];
		endfunction

		function void refresh_frame();
			int unsigned len;
			int          t;
			int          s;
			int          c;
			len = (length_reg == 0) ? 1 : length_reg;
			t = ((int'(step_reg) * 64) / len) % 256;
			s = sine_q14[t];
			c = cosine_q14(t);
			wave_amp = (s + c - Q14One) * 128 / Q14One;
			ang_base = (Q14One - c) * 256 / Q14One + wave_amp;
		endfunction

		function void write_reg(logic [2:0] idx, logic [15:0] data);
			case (idx)
				REG_FRAME_STEP:    step_reg = data;
				REG_EFFECT_LENGTH: length_reg = data;
				REG_TURN_REVERSE:  reverse_reg = data[0];
				REG_FRAME_WIDTH:   width_reg = data[11:0];
				REG_FRAME_HEIGHT:  height_reg = data[11:0];
				default:           return;
			endcase
			refresh_frame();
		endfunction

		function int dim(logic [11:0] v);
			if (v == 0) return 1;
			if (v > MaxDim) return MaxDim;
			return v;
		endfunction

		function int unsigned root32(int unsigned v);
			int unsigned res;
			int unsigned bitv;
			res = 0;
			bitv = 32'h4000_0000;
			while (bitv > v) bitv >>= 2;
			while (bitv != 0) begin
				if (v >= res + bitv) begin
					v -= res + bitv;
					res = (res >> 1) + bitv;
				end else begin
					res >>= 1;
				end
				bitv >>= 2;
			end
			return res;
		endfunction

		function void note_pixel(logic [10:0] col, logic [10:0] row);
			int          w, h, cx, cy, x, y, theta, s, c, jj, ii;
			int unsigned r;
			logic [7:0]  a;
			pixel_t      p;
			w = dim(width_reg);
			h = dim(height_reg);
			cx = w / 2;
			cy = h / 2;
			x = int'(col) - cx;
			y = int'(row) - cy;
			r = root32(16 * (x * x + x + y * y + y) + 8);
			theta = wave_amp * sine_q14[r % 256] / Q14One + ang_base;
			if (reverse_reg) theta = -theta;
			a = theta[7:0];
			s = sine_q14[a];
			c = cosine_q14(a);
			jj = (((2 * x + 1) * c - (2 * y + 1) * s) / Q14One - 1) / 2 + cx;
			ii = (((2 * x + 1) * s + (2 * y + 1) * c) / Q14One - 1) / 2 + cy;
			if (jj < 0) jj = 0;
			if (jj >= w) jj = w - 1;
			if (ii < 0) ii = 0;
			if (ii >= h) ii = h - 1;
			p.col = jj[10:0];
			p.row = ii[10:0];
			src_expected.push_back(p);
		endfunction

		function void check_source(logic [10:0] col, logic [10:0] row);
			pixel_t p;
			if (src_expected.size() == 0) begin
				$error("unexpected word src_col=%0d src_row=%0d", col, row);
				errors++;
				return;
			end
			p = src_expected.pop_front();
			if (col !== p.col) begin
				$error("src_col expected %0d actual %0d", p.col, col);
				errors++;
			end
			if (row !== p.row) begin
				$error("src_row expected %0d actual %0d", p.row, row);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [10:0] dest_col;
	logic [10:0] dest_row;
	logic        out_valid;
	logic        out_stall;
	logic [10:0] src_col;
	logic [10:0] src_row;
	logic        wr_en;
	logic [2:0]  wr_index;
	logic [15:0] wr_data;

	whirl_scoreboard sb;
	int idle_pct;
	int stall_pct;
	int hold_request;
	int hold_left;
	int cycles;

	whirl_source_coordinate dut (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		sb = new();
		idle_pct = 0;
		stall_pct = 0;
		hold_request = 0;
		hold_left = 0;
		cycles = 0;
		arst_n = 0;
		in_valid = 0;
		dest_col = '0;
		dest_row = '0;
		out_stall = 0;
		wr_en = 0;
		wr_index = '0;
		wr_data = '0;
	end

	// both handshakes are sampled here, before this edge's updates land
	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("tb_whirl_source_coordinate: errors");
			$finish;
		end
		if (arst_n && in_valid && !in_stall) sb.note_pixel(dest_col, dest_row);
		if (arst_n && out_valid && !out_stall) sb.check_source(src_col, src_row);
	end

	always @(posedge clk) begin
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	task automatic send_pixel(logic [10:0] col, logic [10:0] row);
		int gap;
		if ($urandom_range(99) < idle_pct) begin
			gap = $urandom_range(1, 4);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		dest_col <= col;
		dest_row <= row;
		do @(posedge clk); while (in_stall);
	endtask

	// lower valid and wait for every expected word, then let the pipe settle
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.src_expected.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] data);
		drain();
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		@(posedge clk);
		wr_en <= 1'b0;
		sb.write_reg(idx, data);
	endtask

	task automatic send_corners();
		int w, h;
		w = sb.dim(sb.width_reg);
		h = sb.dim(sb.height_reg);
		send_pixel(11'd0, 11'd0);
		send_pixel(11'h7FF, 11'h7FF);
		send_pixel(11'(w / 2), 11'(h / 2));
		send_pixel(11'(w - 1), 11'd0);
		send_pixel(11'd0, 11'(h - 1));
	endtask

	task automatic send_random(int count);
		int w, h, n;
		logic [10:0] col, row;
		w = sb.dim(sb.width_reg);
		h = sb.dim(sb.height_reg);
		for (n = 0; n < count; n++) begin
			if ($urandom_range(9) == 0) begin
				col = 11'($urandom);
				row = 11'($urandom);
			end else begin
				col = 11'($urandom_range(w - 1));
				row = 11'($urandom_range(h - 1));
			end
			send_pixel(col, row);
		end
	endtask

	task automatic random_setting();
		write_reg(REG_FRAME_STEP, 16'($urandom));
		write_reg(REG_EFFECT_LENGTH, 16'($urandom_range(1, 65535)));
		write_reg(REG_TURN_REVERSE, 16'($urandom));
		write_reg(REG_FRAME_WIDTH,
			16'($urandom_range(0, 1) ? $urandom_range(1, 2048) : $urandom));
		write_reg(REG_FRAME_HEIGHT,
			16'($urandom_range(0, 1) ? $urandom_range(1, 2048) : $urandom));
	endtask

	initial begin
		int ph;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings first, then the extremes
		send_corners();
		write_reg(REG_FRAME_STEP, 16'hFFFF);
		write_reg(REG_EFFECT_LENGTH, 16'h0000);
		write_reg(REG_TURN_REVERSE, 16'hFFFF);
		write_reg(REG_FRAME_WIDTH, 16'hFFFF);
		write_reg(REG_FRAME_HEIGHT, 16'h0000);
		send_corners();
		write_reg(REG_FRAME_WIDTH, 16'd1);
		write_reg(REG_FRAME_HEIGHT, 16'd2048);
		write_reg(REG_EFFECT_LENGTH, 16'hFFFF);
		send_corners();
		write_reg(REG_SPARE_LO, 16'h0123);
		write_reg(REG_SPARE_HI, 16'hFFFF);
		send_corners();

		for (ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 64; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 64; end
				default: begin idle_pct = 11; stall_pct = 11; end
			endcase
			random_setting();
			send_random(70);
			if (ph == 0) hold_request = 300;
			send_random(70);
			drain();
		end
		idle_pct = 0;
		stall_pct = 0;
		send_random(20);
		drain();

		if (sb.errors == 0 && sb.src_expected.size() == 0)
			$display("tb_whirl_source_coordinate: clean");
		else
			$display("tb_whirl_source_coordinate: errors");
		$finish;
	end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/wsc_pkg.sv
rtl/whirl_source_coordinate.sv
dv/tb_whirl_source_coordinate.sv
